@@ hdl/npec_pkg.sv @@
// Package: shared types and constants of the nearest pad efficiency counter.
package npec_pkg;
    localparam int NUM_PADS_DEF = 1280;
    localparam int IDX_W = 11;
    localparam int POS_W = 16;
    localparam int CNT_W = 32;
    localparam int AMP_W = 40;
    localparam int DIST_W = 35;
    localparam int CFG_W = 34;
    localparam int QD = 2;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TRACK = 2'd1,
        MODE_HIT   = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_FQ_LIMIT  = 2'd0,
        CFG_RADIUS_SQ = 2'd1,
        CFG_AMP_THR   = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_SCAN_END, ST_RD_WAIT,
        ST_RD_DATA, ST_UPDATE, ST_OUT
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [IDX_W-1:0]   pad;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic               q_ok;
        logic [15:0]        amp;
    } t_cmd;
endpackage

@@ hdl/npec_ram.sv @@
// Module: generic single-port-write, single-read RAM with registered read.
module npec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/npec_front.sv @@
// Module: input acceptance, quality cut and command queue.
module npec_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_mode,
    input  logic [npec_pkg::IDX_W-1:0] i_pad_index,
    input  logic signed [15:0]       i_pos_x,
    input  logic signed [15:0]       i_pos_y,
    input  logic [15:0]              i_fit_quality_x,
    input  logic [15:0]              i_fit_quality_y,
    input  logic [15:0]              i_hit_amplitude,
    input  logic [15:0]              i_fq_limit,
    output logic                     o_cmd_valid,
    output npec_pkg::t_cmd           o_cmd,
    input  logic                     i_cmd_take
);
    npec_pkg::t_cmd r_q [npec_pkg::QD];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push;
    npec_pkg::t_cmd cmd_in;

    assign o_stall = (r_cnt == 2'(npec_pkg::QD));
    assign push = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_comb begin
        cmd_in.mode  = npec_pkg::t_mode'(i_mode);
        cmd_in.pad   = i_pad_index;
        cmd_in.pos_x = i_pos_x;
        cmd_in.pos_y = i_pos_y;
        cmd_in.q_ok  = (i_fit_quality_x < i_fq_limit) && (i_fit_quality_y < i_fq_limit);
        cmd_in.amp   = i_hit_amplitude;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_take);
        end
    end
endmodule

@@ hdl/npec_back.sv @@
// Module: pad table, nearest-pad scan, counter updates and result register.
module npec_back #(
    parameter int NUM_PADS = npec_pkg::NUM_PADS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  npec_pkg::t_cmd             i_cmd,
    output logic                       o_cmd_take,
    input  logic [npec_pkg::CFG_W-1:0] i_radius_sq,
    input  logic [15:0]                i_amp_thr,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_result_kind,
    output logic [npec_pkg::IDX_W-1:0] o_matched_pad,
    output logic                       o_track_accepted,
    output logic [31:0]                o_passed_total,
    output logic [31:0]                o_seen_total,
    output logic [39:0]                o_amplitude_sum,
    output logic [31:0]                o_hit_total
);
    localparam int AW = $clog2(NUM_PADS);
    localparam int PW = 2 * npec_pkg::POS_W;
    localparam int CW = 2 * npec_pkg::CNT_W + npec_pkg::AMP_W + npec_pkg::CNT_W;
    localparam logic [npec_pkg::CNT_W-1:0] CMAX = '1;
    localparam logic [npec_pkg::AMP_W-1:0] AMAX = '1;

    npec_pkg::t_state r_st, n_st;
    npec_pkg::t_cmd r_cmd, n_cmd;
    logic [AW-1:0] r_i, n_i, r_si, n_si, r_best, n_best;
    logic [npec_pkg::DIST_W-1:0] r_bd, n_bd;
    logic r_sv, n_sv, r_first, n_first;
    logic [npec_pkg::IDX_W-1:0] r_cur, n_cur;
    logic r_open, n_open, r_done, n_done;
    logic r_acc, n_acc;
    logic [CW-1:0] r_cd, n_cd;
    logic r_ov, n_ov;
    logic r_kind, n_kind;
    logic [npec_pkg::IDX_W-1:0] r_opad, n_opad;
    logic r_oacc, n_oacc;
    logic [CW-1:0] r_ocd, n_ocd;

    logic pwe, cwe;
    logic [AW-1:0] pwa, pra, cwa, cra;
    logic [PW-1:0] pwd, prd;
    logic [CW-1:0] cwd, crd;
    logic [16:0] dx, dy;
    logic [33:0] r_sx, r_sy, n_sx, n_sy;
    logic [npec_pkg::DIST_W-1:0] dsum;
    logic in_rng;
    logic [31:0] cp, cs, ch;
    logic [39:0] ca, asum;
    logic [40:0] aadd;

    npec_ram #(.WIDTH(PW), .DEPTH(NUM_PADS)) u_pos (
        .i_clk(i_clk), .i_we(pwe), .i_waddr(pwa), .i_wdata(pwd),
        .i_raddr(pra), .o_rdata(prd));
    npec_ram #(.WIDTH(CW), .DEPTH(NUM_PADS)) u_cnt (
        .i_clk(i_clk), .i_we(cwe), .i_waddr(cwa), .i_wdata(cwd),
        .i_raddr(cra), .o_rdata(crd));

    assign o_valid = r_ov;
    assign o_result_kind = r_kind;
    assign o_matched_pad = r_opad;
    assign o_track_accepted = r_oacc;
    assign {o_passed_total, o_seen_total, o_amplitude_sum, o_hit_total} = r_ocd;

    assign in_rng = ({{(32-npec_pkg::IDX_W){1'b0}}, r_cmd.pad} < 32'(NUM_PADS));
    assign {cp, cs, ca, ch} = r_cd;
    assign aadd = {1'b0, ca} + 41'(r_cmd.amp);
    assign asum = aadd[40] ? AMAX : aadd[39:0];
    assign dsum = npec_pkg::DIST_W'(r_sx) + npec_pkg::DIST_W'(r_sy);

    always_comb begin
        dx = {r_cmd.pos_x[15], r_cmd.pos_x} - {prd[PW-1], prd[PW-1:16]};
        dy = {r_cmd.pos_y[15], r_cmd.pos_y} - {prd[15], prd[15:0]};
        if (dx[16]) dx = -dx;
        if (dy[16]) dy = -dy;
    end

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_i = r_i; n_si = r_si; n_best = r_best;
        n_bd = r_bd; n_sv = 1'b0; n_first = r_first; n_cur = r_cur;
        n_open = r_open; n_done = r_done; n_acc = r_acc; n_cd = r_cd;
        n_ov = r_ov; n_kind = r_kind; n_opad = r_opad; n_oacc = r_oacc;
        n_ocd = r_ocd;
        n_sx = {2'b0, 32'(dx[15:0]) * 32'(dx[15:0])};
        n_sy = {2'b0, 32'(dy[15:0]) * 32'(dy[15:0])};
        if (dx[16]) n_sx = 34'h1_0000_0000;
        if (dy[16]) n_sy = 34'h1_0000_0000;
        o_cmd_take = 1'b0;
        pwe = 1'b0; pwa = r_cmd.pad[AW-1:0]; pwd = {r_cmd.pos_x, r_cmd.pos_y};
        pra = r_i;
        cwe = 1'b0; cwa = r_i; cwd = '0; cra = r_cmd.pad[AW-1:0];
        if (r_ov && !i_stall) n_ov = 1'b0;
        if (r_sv) begin
            if (r_first || dsum < r_bd) begin
                n_bd = dsum; n_best = r_si; n_first = 1'b0;
            end
        end
        unique case (r_st)
            npec_pkg::ST_CLEAR: begin
                cwe = 1'b1; cwa = r_i; pwe = 1'b1; pwa = r_i; pwd = '0;
                n_i = r_i + 1'b1;
                if (32'(r_i) == 32'(NUM_PADS - 1)) n_st = npec_pkg::ST_IDLE;
            end
            npec_pkg::ST_IDLE: begin
                if (i_cmd_valid && !r_ov) begin
                    o_cmd_take = 1'b1;
                    n_cmd = i_cmd;
                    n_i = '0;
                    n_first = 1'b1;
                    unique case (i_cmd.mode)
                        npec_pkg::MODE_TRACK: n_st = npec_pkg::ST_SCAN;
                        npec_pkg::MODE_LOAD: n_st = npec_pkg::ST_UPDATE;
                        default: n_st = npec_pkg::ST_RD_WAIT;
                    endcase
                end
            end
            npec_pkg::ST_SCAN: begin
                n_i = r_i + 1'b1;
                n_si = r_i;
                if (32'(r_i) == 32'(NUM_PADS - 1)) n_st = npec_pkg::ST_SCAN_LAST;
            end
            npec_pkg::ST_SCAN_LAST: begin
                n_sv = 1'b1; n_si = r_i - 1'b1; n_st = npec_pkg::ST_SCAN_END;
            end
            npec_pkg::ST_SCAN_END: begin
                n_st = npec_pkg::ST_RD_WAIT;
            end
            npec_pkg::ST_RD_WAIT: begin
                if (r_cmd.mode == npec_pkg::MODE_TRACK) begin
                    cra = r_best;
                    n_acc = r_cmd.q_ok && ({1'b0, i_radius_sq} >= r_bd);
                end
                n_st = npec_pkg::ST_RD_DATA;
            end
            npec_pkg::ST_RD_DATA: begin
                n_cd = crd;
                n_st = npec_pkg::ST_UPDATE;
            end
            npec_pkg::ST_UPDATE: begin
                n_st = npec_pkg::ST_IDLE;
                unique case (r_cmd.mode)
                    npec_pkg::MODE_LOAD: pwe = in_rng;
                    npec_pkg::MODE_HIT: begin
                        cwa = r_cmd.pad[AW-1:0];
                        cwe = in_rng;
                        if (r_open && !r_done && r_cmd.amp > i_amp_thr &&
                            r_cmd.pad == r_cur) begin
                            cwd = {cp, (cs == CMAX) ? cs : cs + 1'b1, asum,
                                   (ch == CMAX) ? ch : ch + 1'b1};
                            if (in_rng) n_done = 1'b1;
                        end else begin
                            cwd = {cp, cs, asum, (ch == CMAX) ? ch : ch + 1'b1};
                        end
                    end
                    npec_pkg::MODE_TRACK: begin
                        cwa = r_best;
                        cwd = {(r_acc && cp != CMAX) ? cp + 1'b1 : cp, cs, ca, ch};
                        cwe = r_acc;
                        n_cur = npec_pkg::IDX_W'(r_best);
                        n_open = r_acc; n_done = 1'b0;
                        n_ov = 1'b1; n_kind = 1'b0;
                        n_opad = npec_pkg::IDX_W'(r_best);
                        n_oacc = r_acc; n_ocd = cwd;
                    end
                    default: begin
                        n_ov = 1'b1; n_kind = 1'b1; n_opad = r_cmd.pad;
                        n_oacc = 1'b0; n_ocd = in_rng ? r_cd : '0;
                    end
                endcase
            end
            default: n_st = npec_pkg::ST_IDLE;
        endcase
        if (r_st == npec_pkg::ST_SCAN && r_i != '0) n_sv = 1'b1;
        if (r_st == npec_pkg::ST_SCAN) n_si = r_i - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_si <= n_si; r_best <= n_best; r_bd <= n_bd;
        r_acc <= n_acc; r_cd <= n_cd; r_kind <= n_kind; r_opad <= n_opad;
        r_oacc <= n_oacc; r_ocd <= n_ocd; r_sx <= n_sx; r_sy <= n_sy;
        r_first <= n_first;
        if (!i_rst_n) begin
            r_st <= npec_pkg::ST_CLEAR; r_i <= '0; r_sv <= 1'b0; r_cur <= '0;
            r_open <= 1'b0; r_done <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_i <= n_i; r_sv <= n_sv; r_cur <= n_cur;
            r_open <= n_open; r_done <= n_done; r_ov <= n_ov;
        end
    end
endmodule

@@ hdl/nearest_pad_efficiency_counter.sv @@
// Top level: nearest pad matcher with per-pad efficiency counters.
// A track item scans every pad position in the position RAM, one pad per
// cycle, then reads the counters of the nearest pad and updates them if the
// track is accepted; a load item writes the position RAM, and hit and read
// items read the counter RAM, which a hit then writes back. The back end takes
// no new item while a result waits on the output. Input items queue in a
// two-entry buffer ahead of the back end. After reset a clearing pass zeroes
// both RAMs before the first item is processed; items are queued meanwhile.
module nearest_pad_efficiency_counter #(
    parameter int NUM_PADS = npec_pkg::NUM_PADS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic [10:0]        i_pad_index,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [15:0]        i_fit_quality_x,
    input  logic [15:0]        i_fit_quality_y,
    input  logic [15:0]        i_hit_amplitude,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [33:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_result_kind,
    output logic [10:0]        o_matched_pad,
    output logic               o_track_accepted,
    output logic [31:0]        o_passed_total,
    output logic [31:0]        o_seen_total,
    output logic [39:0]        o_amplitude_sum,
    output logic [31:0]        o_hit_total
);
    logic [15:0] r_fq, r_thr;
    logic [33:0] r_rad;
    logic cmd_valid, cmd_take;
    npec_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fq <= 16'd102; r_rad <= 34'd16384; r_thr <= 16'd50;
        end else if (i_cfg_we) begin
            unique case (npec_pkg::t_cfg_idx'(i_cfg_index))
                npec_pkg::CFG_FQ_LIMIT:  r_fq <= i_cfg_data[15:0];
                npec_pkg::CFG_RADIUS_SQ: r_rad <= i_cfg_data;
                npec_pkg::CFG_AMP_THR:   r_thr <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    npec_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_pad_index(i_pad_index), .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y), .i_fit_quality_x(i_fit_quality_x),
        .i_fit_quality_y(i_fit_quality_y), .i_hit_amplitude(i_hit_amplitude),
        .i_fq_limit(r_fq), .o_cmd_valid(cmd_valid), .o_cmd(cmd),
        .i_cmd_take(cmd_take));

    npec_back #(.NUM_PADS(NUM_PADS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .i_radius_sq(r_rad), .i_amp_thr(r_thr),
        .o_valid(o_valid), .i_stall(i_stall), .o_result_kind(o_result_kind),
        .o_matched_pad(o_matched_pad), .o_track_accepted(o_track_accepted),
        .o_passed_total(o_passed_total), .o_seen_total(o_seen_total),
        .o_amplitude_sum(o_amplitude_sum), .o_hit_total(o_hit_total));
endmodule
